@@ rtl/core/modbus_rtu_read_response_checker_top_defines.svh @@
// ----------------------------------------------------------------------------
// modbus rtu reply checker assertion macros
// shared assertion forms for the reply checker, clocked on clk and held off
// while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_READ_RESPONSE_CHECKER_TOP_DEFINES_SVH
`define MODBUS_RTU_READ_RESPONSE_CHECKER_TOP_DEFINES_SVH

// same-cycle implication
`define MBRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mbrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrc_pkg
// types, codes and the crc-16/modbus byte step for the modbus rtu reply checker
// ----------------------------------------------------------------------------
package mbrc_pkg;

  typedef logic [15:0] word_t;
  typedef logic [1:0]  func_t;
  typedef logic [1:0]  status_t;
  typedef logic [4:0]  byte_idx_t;

  // item selector codes
  localparam func_t FN_BEGIN   = 2'd0;
  localparam func_t FN_BYTE    = 2'd1;
  localparam func_t FN_TIMEOUT = 2'd2;

  // result status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_CRC     = 2'd1;
  localparam status_t ST_HEADER  = 2'd2;
  localparam status_t ST_TIMEOUT = 2'd3;

  // register indexes
  localparam int unsigned REG_SLAVE_ADDR = 0;

  localparam word_t     CRC_INIT      = 16'hFFFF;
  localparam word_t     CRC_POLY      = 16'hA001;
  localparam logic [7:0] FUNC_READ    = 8'h03;
  localparam int unsigned WORD_COUNT  = 6;
  localparam logic [7:0] BYTE_COUNT   = 8'(WORD_COUNT * 2);
  localparam byte_idx_t PAYLOAD_BYTES = 5'(3 + WORD_COUNT * 2);
  localparam byte_idx_t FRAME_BYTES   = 5'(5 + WORD_COUNT * 2);
  localparam word_t     FAIL_MAX      = 16'hFFFF;

  // one byte through the reflected crc, eight shift steps
  function automatic word_t crc_byte(input word_t crc_in, input logic [7:0] b);
    word_t c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/modbus_rtu_read_response_checker_top.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_read_response_checker_top
// checks a 17-byte modbus rtu read-holding-registers reply and reports status
// ----------------------------------------------------------------------------
// A begin item opens a poll; byte items then carry the reply (address,
// function 3, byte count 12, six big-endian words, crc low, crc high) and a
// timeout item closes a poll that is still short. crc-16/modbus is folded in
// one byte per cycle, so the block takes one item every clock unless stalled:
// each item is fully handled in the cycle it is accepted and the single output
// register holds the result. A poll that ends (last trailer byte or timeout)
// gives one result in the cycle after acceptance; begin, data bytes, stray
// items and selector 3 give none. in_tready drops only while a result waits
// in the output register and the sink is not taking it. The result always
// carries the last good words (zero until a good frame), the online flag and
// a saturating failure count. slave_address is written over the apb-style port
// at byte address 0 and must only change while the block is idle.
// ----------------------------------------------------------------------------
module modbus_rtu_read_response_checker_top (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  mbrc_pkg::func_t       in_tuser,   // [1:0] func
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] voltage_word, [31:16] current_word, [47:32] power_word,
  // [79:48] energy_count, [95:80] power_factor_word, [96] online,
  // [112:97] error_count, [119:113] zero
  output logic [119:0]          out_tdata,
  output mbrc_pkg::status_t     out_tuser,  // [1:0] status
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import mbrc_pkg::*;

  `include "modbus_rtu_read_response_checker_top_defines.svh"

  // configuration
  logic [7:0] slave_addr_r;
  logic       cfg_wr;

  // frame state
  word_t      crc_acc_r,   crc_acc_nxt;
  byte_idx_t  byte_idx_r,  byte_idx_nxt;
  logic       poll_act_r,  poll_act_nxt;
  logic       hdr_bad_r,   hdr_bad_nxt;
  logic [7:0] crc_lo_r,    crc_lo_nxt;
  word_t      frame_w_r [WORD_COUNT];
  word_t      frame_w_nxt [WORD_COUNT];
  word_t      good_w_r [WORD_COUNT];
  word_t      good_w_nxt [WORD_COUNT];
  logic       online_r,    online_nxt;
  word_t      fail_cnt_r,  fail_cnt_nxt;

  // output register
  logic           out_valid_r, out_valid_nxt;
  status_t        out_status_r, out_status_nxt;
  logic [119:0]   out_data_r, out_data_nxt;

  logic           in_acc;
  logic           emit;
  status_t        emit_status;
  logic           fail;
  logic [3:0]     off;
  logic [2:0]     widx;
  word_t          crc_step;
  word_t          crc_got;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                    & (cfg_paddr == 3'(REG_SLAVE_ADDR * 4));
  assign cfg_prdata = (cfg_paddr == 3'(REG_SLAVE_ADDR * 4)) ? {24'h0, slave_addr_r} : 32'h0;

  // accept whenever the output slot is free or being drained
  assign in_tready  = ~out_valid_r | out_tready;
  assign in_acc     = in_tvalid & in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

  // word slot and byte half for payload bytes 3..14
  assign off      = 4'(byte_idx_r - 5'd3);
  assign widx     = off[3:1];
  assign crc_step = crc_byte(crc_acc_r, in_tdata);
  assign crc_got  = {in_tdata, crc_lo_r};

  always_comb begin
    crc_acc_nxt  = crc_acc_r;
    byte_idx_nxt = byte_idx_r;
    poll_act_nxt = poll_act_r;
    hdr_bad_nxt  = hdr_bad_r;
    crc_lo_nxt   = crc_lo_r;
    frame_w_nxt  = frame_w_r;
    good_w_nxt   = good_w_r;
    emit         = 1'b0;
    emit_status  = ST_OK;
    fail         = 1'b0;

    if (in_acc) begin
      case (in_tuser)
        FN_BEGIN: begin
          crc_acc_nxt  = CRC_INIT;
          byte_idx_nxt = '0;
          poll_act_nxt = 1'b1;
          hdr_bad_nxt  = 1'b0;
        end
        FN_TIMEOUT: begin
          if (poll_act_r) begin
            poll_act_nxt = 1'b0;
            emit         = 1'b1;
            emit_status  = ST_TIMEOUT;
            fail         = 1'b1;
          end
        end
        FN_BYTE: begin
          if (poll_act_r) begin
            byte_idx_nxt = byte_idx_r + 5'd1;
            if (byte_idx_r < PAYLOAD_BYTES) begin
              crc_acc_nxt = crc_step;
              if (byte_idx_r == 5'd0) begin
                if (in_tdata != slave_addr_r) hdr_bad_nxt = 1'b1;
              end else if (byte_idx_r == 5'd1) begin
                if (in_tdata != FUNC_READ) hdr_bad_nxt = 1'b1;
              end else if (byte_idx_r == 5'd2) begin
                if (in_tdata != BYTE_COUNT) hdr_bad_nxt = 1'b1;
              end else if (!off[0]) begin
                frame_w_nxt[widx][15:8] = in_tdata;
              end else begin
                frame_w_nxt[widx][7:0] = in_tdata;
              end
            end else if (byte_idx_r == PAYLOAD_BYTES) begin
              crc_lo_nxt = in_tdata;
            end else begin
              // last trailer byte closes the poll
              poll_act_nxt = 1'b0;
              emit         = 1'b1;
              if (crc_got != crc_acc_r) begin
                emit_status = ST_CRC;
                fail        = 1'b1;
              end else if (hdr_bad_r) begin
                emit_status = ST_HEADER;
                fail        = 1'b1;
              end else begin
                emit_status = ST_OK;
                good_w_nxt  = frame_w_r;
              end
            end
          end
        end
        default: begin
          // selector 3 does nothing
        end
      endcase
    end

    online_nxt   = online_r;
    fail_cnt_nxt = fail_cnt_r;
    if (emit) begin
      online_nxt = ~fail;
      if (fail && (fail_cnt_r != FAIL_MAX)) begin
        fail_cnt_nxt = fail_cnt_r + 16'd1;
      end
    end

    // output slot: load on a result, drop once taken
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = emit_status;
      out_data_nxt   = {7'h00, fail_cnt_nxt, online_nxt, good_w_nxt[5],
                        good_w_nxt[3], good_w_nxt[4], good_w_nxt[2],
                        good_w_nxt[1], good_w_nxt[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'h01;
      crc_acc_r    <= CRC_INIT;
      byte_idx_r   <= '0;
      poll_act_r   <= 1'b0;
      hdr_bad_r    <= 1'b0;
      online_r     <= 1'b0;
      fail_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < WORD_COUNT; i++) begin
        good_w_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        slave_addr_r <= cfg_pwdata[7:0];
      end
      crc_acc_r   <= crc_acc_nxt;
      byte_idx_r  <= byte_idx_nxt;
      poll_act_r  <= poll_act_nxt;
      hdr_bad_r   <= hdr_bad_nxt;
      online_r    <= online_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      good_w_r    <= good_w_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    crc_lo_r     <= crc_lo_nxt;
    frame_w_r    <= frame_w_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // assertions
  `MBRC_ASSERT_NOW(a_ok_online, out_valid_r, (out_status_r == ST_OK) == out_data_r[96],
    "online bit disagrees with result status")
  `MBRC_ASSERT_NEXT(a_timeout_result,
    in_acc && (in_tuser == FN_TIMEOUT) && poll_act_r,
    out_valid_r && (out_status_r == ST_TIMEOUT), "timeout did not produce a result")
  `MBRC_ASSERT_NOW(a_frame_end_closed, byte_idx_r == FRAME_BYTES, !poll_act_r,
    "poll still open after full frame")
  `MBRC_ASSERT_NEXT(a_fail_monotonic, 1'b1, fail_cnt_r >= $past(fail_cnt_r),
    "failure count went down")

endmodule
